// ===== rtl/thps_pkg.sv =====
// ----------------------------------------------------------------------------
// thps_pkg
// Shared widths, constants and types of the temperature/humidity poll
// sequencer.
// ----------------------------------------------------------------------------
package thps_pkg;

    localparam int COUNT_WIDTH_DEF = 24;

    localparam int RAW_W      = 16;
    localparam int SHORT_W    = 16;
    localparam int LONG_W     = 24;
    localparam int CAL_W      = 12;
    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // sensor transfer functions in fixed point (scale over 2^16)
    localparam int TEMP_SCALE  = 16500;
    localparam int TEMP_OFFSET = 4000;
    localparam int HUM_SCALE   = 10000;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
    } thps_meas_t;

endpackage

// ===== rtl/temp_humidity_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// temp_humidity_poll_sequencer
// Tick counter and poll sequencer for a temperature/humidity sensor.
//
//   channel  | dir | fields
//   ---------+-----+-------------------------------------------------------
//   s_*      | in  | tuser: kind; tdata: rx_word
//   m_*      | out | tdata: command, temperature, humidity; tuser: flags
//   cfg_*    | in  | 0 short_wait, 1 long_wait, 2 temp_calibration
//
// One item per cycle sustained while m_tready stays high; each item passes the
// input register, then the result register, before m_tvalid rises. Sequencer
// state is updated when an item moves from the input register into the result
// register, which happens whenever the result register is empty or being taken.
// Reset sets the initialize phase, a zero counter, -100.00 degrees and zero
// humidity, and the register defaults 20, 30000, -7.00 degrees.
// ----------------------------------------------------------------------------
module temp_humidity_poll_sequencer
#(
    parameter int COUNT_WIDTH = thps_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] rx_word
    input  logic [0:0]                     s_tuser,   // [0] kind

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [1:0] command, [16:2] temperature,
                                                      // [30:17] humidity, [31] zero
    output logic [1:0]                     m_tuser,   // [0] temp_updated, [1] hum_updated

    input  logic                           cfg_wen,
    input  logic [thps_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [thps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import thps_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_SLEEP = 3'd1;
    localparam logic [2:0] PH_TREQ  = 3'd2;
    localparam logic [2:0] PH_TREAD = 3'd3;
    localparam logic [2:0] PH_HREQ  = 3'd4;
    localparam logic [2:0] PH_HREAD = 3'd5;

    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONFIG  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POINTER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL   = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [SHORT_W-1:0]      short_wait_reg;
    logic [LONG_W-1:0]       long_wait_reg;
    logic signed [CAL_W-1:0] temp_cal_reg;

    // input register
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [RAW_W-1:0] in_raw_reg;

    // sequencer state
    logic [2:0]               phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   tick_reg, tick_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [HUM_W-1:0]         hum_reg, hum_next;

    // result register
    logic             out_valid_reg;
    logic [CMD_W-1:0] out_cmd_reg;
    logic [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0] out_hum_reg;
    logic             out_tupd_reg;
    logic             out_hupd_reg;

    logic [CMD_W-1:0] cmd_next;
    logic             tupd_next;
    logic             hupd_next;
    logic             advance;
    logic             short_done;
    logic             long_done;
    thps_meas_t       meas;

    thps_convert u_convert
    (
        .raw  (in_raw_reg),
        .cal  (temp_cal_reg),
        .meas (meas)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign short_done = CMP_W'(tick_reg) > CMP_W'(short_wait_reg);
    assign long_done  = CMP_W'(tick_reg) > CMP_W'(long_wait_reg);

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        cmd_next   = CMD_NONE;
        tupd_next  = 1'b0;
        hupd_next  = 1'b0;
        if (!in_kind_reg)
        begin
            if (tick_reg != COUNT_TOP)
            begin
                tick_next = tick_reg + 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_INIT:
                begin
                    cmd_next   = CMD_CONFIG;
                    tick_next  = '0;
                    phase_next = PH_SLEEP;
                end
                PH_SLEEP:
                begin
                    // leaving sleep issues nothing; the request comes next poll
                    if (long_done)
                    begin
                        tick_next  = '0;
                        phase_next = PH_TREQ;
                    end
                end
                PH_TREQ:
                begin
                    cmd_next   = CMD_POINTER;
                    tick_next  = '0;
                    phase_next = PH_TREAD;
                end
                PH_TREAD:
                begin
                    if (short_done)
                    begin
                        cmd_next   = CMD_READ;
                        temp_next  = meas.temp;
                        tupd_next  = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_HREQ;
                    end
                end
                PH_HREQ:
                begin
                    if (short_done)
                    begin
                        cmd_next   = CMD_POINTER;
                        tick_next  = '0;
                        phase_next = PH_HREAD;
                    end
                end
                PH_HREAD:
                begin
                    if (short_done)
                    begin
                        cmd_next   = CMD_READ;
                        hum_next   = meas.hum;
                        hupd_next  = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_SLEEP;
                    end
                end
                default:
                begin
                    tick_next  = '0;
                    phase_next = PH_SLEEP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_wait_reg <= SHORT_W'(20);
            long_wait_reg  <= LONG_W'(30000);
            temp_cal_reg   <= -CAL_W'(700);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_SHORT_WAIT: short_wait_reg <= cfg_wdata[SHORT_W-1:0];
                REG_LONG_WAIT:  long_wait_reg  <= cfg_wdata[LONG_W-1:0];
                REG_TEMP_CAL:   temp_cal_reg   <= cfg_wdata[CAL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_INIT;
            tick_reg      <= '0;
            temp_reg      <= -TEMP_W'(10000);
            hum_reg       <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                temp_reg      <= temp_next;
                hum_reg       <= hum_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser[0];
            in_raw_reg  <= s_tdata;
        end
        if (advance)
        begin
            out_cmd_reg  <= cmd_next;
            out_temp_reg <= temp_next;
            out_hum_reg  <= hum_next;
            out_tupd_reg <= tupd_next;
            out_hupd_reg <= hupd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_hum_reg, out_temp_reg, out_cmd_reg};
    assign m_tuser  = {out_hupd_reg, out_tupd_reg};

endmodule

// ===== rtl/thps_convert.sv =====
// ----------------------------------------------------------------------------
// thps_convert
// Converts a raw sensor word into centidegrees and centi-percent humidity.
// ----------------------------------------------------------------------------
module thps_convert
(
    input  logic [thps_pkg::RAW_W-1:0]        raw,
    input  logic signed [thps_pkg::CAL_W-1:0] cal,
    output thps_pkg::thps_meas_t              meas
);
    import thps_pkg::*;

    localparam int TPROD_W = RAW_W + 15;
    localparam int HPROD_W = RAW_W + HUM_W;

    logic [TPROD_W-1:0]      t_prod;
    logic [HPROD_W-1:0]      h_prod;
    logic signed [RAW_W-1:0] t_sum;

    always_comb
    begin
        t_prod = TPROD_W'(raw) * TPROD_W'(TEMP_SCALE);
        h_prod = HPROD_W'(raw) * HPROD_W'(HUM_SCALE);
        // scaled value is below 16500, so 15 bits plus a sign bit hold it
        t_sum  = $signed({1'b0, t_prod[TPROD_W-1:RAW_W]})
               - $signed(RAW_W'(TEMP_OFFSET))
               + $signed({{(RAW_W-CAL_W){cal[CAL_W-1]}}, cal});
        meas.temp = t_sum[TEMP_W-1:0];
        meas.hum  = h_prod[HPROD_W-1:RAW_W];
    end

endmodule

// ===== tb/sv/thps_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thps_tb_pkg
// Codes shared by the poll sequencer testbench top and its checker: item
// kinds, bus commands and configuration register indexes.
// ----------------------------------------------------------------------------
package thps_tb_pkg;

    typedef enum logic
    {
        KIND_TICK = 1'b0,
        KIND_POLL = 1'b1
    } item_kind_e;

    typedef enum logic [1:0]
    {
        CMD_NONE    = 2'd0,
        CMD_CONFIG  = 2'd1,
        CMD_POINTER = 2'd2,
        CMD_READ    = 2'd3
    } bus_cmd_e;

    typedef enum logic [1:0]
    {
        REG_SHORT_WAIT = 2'd0,
        REG_LONG_WAIT  = 2'd1,
        REG_TEMP_CAL   = 2'd2
    } cfg_reg_e;

endpackage

// ===== tb/sv/thps_poll_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thps_poll_checker
// Watches the input, result and register write channels of the poll
// sequencer, keeps its own copy of the sequencer state and compares every
// result transfer, field by field, with the oldest predicted sensor report.
// ----------------------------------------------------------------------------
module thps_poll_checker
    import thps_pkg::*;
    import thps_tb_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] rx_word
    input  logic [0:0]            s_tuser,   // [0] kind

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [1:0] command, [16:2] temperature,
                                             // [30:17] humidity, [31] zero
    input  logic [1:0]            m_tuser,   // [0] temp_updated, [1] hum_updated

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    output int                    fail_count,
    output int                    pending,
    output int                    reports_checked,
    output int                    temp_reads,
    output int                    hum_reads
);

    typedef enum logic [2:0]
    {
        PH_INIT  = 3'd0,
        PH_SLEEP = 3'd1,
        PH_TREQ  = 3'd2,
        PH_TREAD = 3'd3,
        PH_HREQ  = 3'd4,
        PH_HREAD = 3'd5
    } poll_phase_e;

    typedef struct packed
    {
        bus_cmd_e                 cmd;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic                     temp_upd;
        logic                     hum_upd;
    } sensor_report_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    poll_phase_e              phase;
    logic [COUNT_WIDTH-1:0]   ticks;
    logic signed [TEMP_W-1:0] temp_now;
    logic [HUM_W-1:0]         hum_now;
    logic [SHORT_W-1:0]       short_wait;
    logic [LONG_W-1:0]        long_wait;
    logic signed [CAL_W-1:0]  temp_cal;

    sensor_report_t expected_reports[$];
    int errors;
    int n_checked;
    int n_temp;
    int n_hum;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        errors++;
    endtask

    // one item through the sequencer: a tick bumps the counter, a poll moves
    // at most one step
    task automatic step_sequencer(input logic kind, input logic [15:0] raw,
                                  output sensor_report_t rep);
        int unsigned prod;
        int          t;
        rep.cmd      = CMD_NONE;
        rep.temp_upd = 1'b0;
        rep.hum_upd  = 1'b0;
        if (kind == KIND_TICK)
        begin
            if (ticks != COUNT_TOP)
                ticks = ticks + 1'b1;
        end
        else
        begin
            case (phase)
                PH_INIT:
                begin
                    rep.cmd = CMD_CONFIG;
                    ticks   = '0;
                    phase   = PH_SLEEP;
                end
                PH_SLEEP:
                begin
                    // leaving sleep issues nothing, the request comes next poll
                    if (ticks > long_wait)
                    begin
                        ticks = '0;
                        phase = PH_TREQ;
                    end
                end
                PH_TREQ:
                begin
                    rep.cmd = CMD_POINTER;
                    ticks   = '0;
                    phase   = PH_TREAD;
                end
                PH_TREAD:
                begin
                    if (ticks > short_wait)
                    begin
                        prod         = 32'(raw) * 32'(TEMP_SCALE);
                        t            = int'(prod >> 16) - TEMP_OFFSET + int'(temp_cal);
                        temp_now     = t[TEMP_W-1:0];
                        rep.cmd      = CMD_READ;
                        rep.temp_upd = 1'b1;
                        ticks        = '0;
                        phase        = PH_HREQ;
                    end
                end
                PH_HREQ:
                begin
                    if (ticks > short_wait)
                    begin
                        rep.cmd = CMD_POINTER;
                        ticks   = '0;
                        phase   = PH_HREAD;
                    end
                end
                PH_HREAD:
                begin
                    if (ticks > short_wait)
                    begin
                        prod        = 32'(raw) * 32'(HUM_SCALE);
                        hum_now     = HUM_W'(prod >> 16);
                        rep.cmd     = CMD_READ;
                        rep.hum_upd = 1'b1;
                        ticks       = '0;
                        phase       = PH_SLEEP;
                    end
                end
                default:
                begin
                    ticks = '0;
                    phase = PH_SLEEP;
                end
            endcase
        end
        rep.temp = temp_now;
        rep.hum  = hum_now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sensor_report_t rep;
        sensor_report_t want;
        if (!rst_n)
        begin
            phase      = PH_INIT;
            ticks      = '0;
            temp_now   = -15'sd10000;
            hum_now    = '0;
            short_wait = 16'd20;
            long_wait  = 24'd30000;
            temp_cal   = -12'sd700;
            expected_reports.delete();
            errors     = 0;
            n_checked  = 0;
            n_temp     = 0;
            n_hum      = 0;
        end
        else
        begin
            // a result comes only from an earlier input, so compare before predicting
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing pending, tdata %h",
                                              m_tdata));
                else
                begin
                    want = expected_reports.pop_front();
                    n_checked++;
                    if (m_tdata[1:0] != want.cmd)
                        report_mismatch($sformatf("command got %0d expected %0d",
                                                  m_tdata[1:0], want.cmd));
                    if ($signed(m_tdata[16:2]) != want.temp)
                        report_mismatch($sformatf("temperature got %0d expected %0d",
                                                  $signed(m_tdata[16:2]), want.temp));
                    if (m_tdata[30:17] != want.hum)
                        report_mismatch($sformatf("humidity got %0d expected %0d",
                                                  m_tdata[30:17], want.hum));
                    if (m_tdata[31] != 1'b0)
                        report_mismatch("tdata pad bit set");
                    if (m_tuser[0] != want.temp_upd)
                        report_mismatch($sformatf("temp_updated got %0b expected %0b",
                                                  m_tuser[0], want.temp_upd));
                    if (m_tuser[1] != want.hum_upd)
                        report_mismatch($sformatf("hum_updated got %0b expected %0b",
                                                  m_tuser[1], want.hum_upd));
                    if (want.temp_upd)
                        n_temp++;
                    if (want.hum_upd)
                        n_hum++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                step_sequencer(s_tuser[0], s_tdata, rep);
                expected_reports.push_back(rep);
            end

            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_SHORT_WAIT: short_wait = cfg_wdata[SHORT_W-1:0];
                    REG_LONG_WAIT:  long_wait  = cfg_wdata[LONG_W-1:0];
                    REG_TEMP_CAL:   temp_cal   = cfg_wdata[CAL_W-1:0];
                    default:        ;
                endcase
            end
        end

        fail_count      <= errors;
        pending         <= expected_reports.size();
        reports_checked <= n_checked;
        temp_reads      <= n_temp;
        hum_reads       <= n_hum;
    end

endmodule

// ===== tb/sv/tb_temp_humidity_poll_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temp_humidity_poll_sequencer
// Drives ticks and polls into the poll sequencer under several register
// settings, with random gaps and stalls on both channels; the checker
// predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_temp_humidity_poll_sequencer;

    import thps_pkg::*;
    import thps_tb_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [15:0] rx_word
    logic [0:0]            s_tuser;   // [0] kind

    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // [1:0] command, [16:2] temperature,
                                      // [30:17] humidity, [31] zero
    logic [1:0]            m_tuser;   // [0] temp_updated, [1] hum_updated

    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int reports_checked;
    int temp_reads;
    int hum_reads;

    int gap_max;
    int items_sent;
    int reg_writes;

    always #10 clk = ~clk;

    temp_humidity_poll_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    thps_poll_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wen         (cfg_wen),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_checked (reports_checked),
        .temp_reads      (temp_reads),
        .hum_reads       (hum_reads)
    );

    task automatic send_item(input item_kind_e kind, input logic [15:0] raw);
        int gap;
        gap = $urandom_range(gap_max, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = raw;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wen   = 1'b0;
        reg_writes++;
    endtask

    task automatic set_waits(input logic [15:0] sw, input logic [23:0] lw, input int cal);
        write_reg(REG_SHORT_WAIT, CFG_DATA_W'(sw));
        write_reg(REG_LONG_WAIT, lw);
        write_reg(REG_TEMP_CAL, CFG_DATA_W'(cal));
    endtask

    task automatic random_burst(input int count);
        logic [15:0] raw;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9, 0))
                0:       raw = 16'h0000;
                1:       raw = 16'hFFFF;
                default: raw = 16'($urandom());
            endcase
            send_item(($urandom_range(99, 0) < 35) ? KIND_POLL : KIND_TICK, raw);
        end
    endtask

    // result side: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int w;
        int taken;
        bit no_stall;
        m_tready = 1'b0;
        taken    = 0;
        no_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 64 == 0)
                no_stall = ($urandom_range(2, 0) == 0);
            if (taken == 400)
                w = 80;
            else if (no_stall)
                w = 0;
            else
                w = $urandom_range(10, 0);
            if (w > 0)
            begin
                m_tready = 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin
        #4_000_000;
        $display("timeout: %0d results still pending", pending);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_wen    = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        gap_max    = 10;
        items_sent = 0;
        reg_writes = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: init step, then sleep that cannot end yet
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_POLL, 16'h0000);
        send_item(KIND_POLL, 16'hFFFF);
        send_item(KIND_TICK, 16'h0000);

        // zero waits, calibration -20.00 degrees, full-scale readings
        drain();
        set_waits(16'd0, 24'd0, -2000);
        send_item(KIND_POLL, 16'h1234);
        send_item(KIND_POLL, 16'h0000);
        send_item(KIND_POLL, 16'hFFFF);   // read before the wait is over
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_POLL, 16'hFFFF);
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_POLL, 16'h0000);
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_POLL, 16'hFFFF);

        // calibration +20.00 degrees, zero readings
        drain();
        write_reg(REG_TEMP_CAL, CFG_DATA_W'(2000));
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_POLL, 16'hFFFF);
        send_item(KIND_POLL, 16'hFFFF);
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_POLL, 16'h0000);
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_POLL, 16'hFFFF);
        send_item(KIND_TICK, 16'hFFFF);
        send_item(KIND_POLL, 16'h0000);

        // waits too long to ever end
        drain();
        set_waits(16'hFFFF, 24'hFFFFFF, -700);
        send_item(KIND_TICK, 16'h5A5A);
        send_item(KIND_POLL, 16'hA5A5);
        send_item(KIND_TICK, 16'h5A5A);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            gap_max = (p % 3 == 1) ? 0 : 10;
            set_waits(16'($urandom_range(4, 0)), 24'($urandom_range(6, 0)),
                      int'($urandom_range(4000, 0)) - 2000);
            random_burst(125);
        end

        // unreachable waits with the sequencer somewhere mid-round
        drain();
        gap_max = 10;
        set_waits(16'hFFFF, 24'hFFFFFF, int'($urandom_range(4000, 0)) - 2000);
        random_burst(30);
        drain();

        $display("sent %0d ticks and polls over %0d register writes", items_sent, reg_writes);
        $display("checked %0d results: %0d temperature and %0d humidity readings",
                 reports_checked, temp_reads, hum_reads);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
